// ----- sv/lzbd_pkg.sv -----
// lzbd_pkg: shared constants, types and helpers for the lz4 block decoder
// depends on nothing; imported by lz4_block_decoder

package lzbd_pkg;

  // history window, power-of-two depth so addresses wrap for free
  localparam int WINDOW_DEPTH = 65536;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int PROD_W       = WIN_AW + 1;

  // run lengths saturate at all ones
  localparam int LENGTH_WIDTH = 32;

  // token and length coding
  localparam logic [3:0] EXT_NIBBLE = 4'd15;
  localparam logic [7:0] EXT_BYTE   = 8'd255;
  localparam int         MIN_MATCH  = 4;

  // operation codes of an input beat
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // decode phases
  typedef enum logic [2:0] {
    PH_TOKEN    = 3'd0,
    PH_LITEXT   = 3'd1,
    PH_LIT      = 3'd2,
    PH_OFF0     = 3'd3,
    PH_OFF1     = 3'd4,
    PH_MATCHEXT = 3'd5,
    PH_MATCH    = 3'd6,
    PH_MATCHFIN = 3'd7
  } phase_t;

  // result status codes
  localparam logic [2:0] ST_RUN       = 3'd0;
  localparam logic [2:0] ST_ZERO_END  = 3'd1;
  localparam logic [2:0] ST_INPUT_END = 3'd2;
  localparam logic [2:0] ST_BAD_DIST  = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;
  localparam logic [2:0] ST_REFUSED   = 3'd5;

  // result beat between decode and output register
  typedef struct packed {
    logic              mem_src;
    logic              emit;
    logic [7:0]        lit;
    logic [2:0]        status;
    logic [WIN_AW-1:0] waddr;
  } s1_t;

  // saturating add of one extension byte to a run length
  function automatic logic [LENGTH_WIDTH-1:0] sat_add(input logic [LENGTH_WIDTH-1:0] a,
                                                      input logic [7:0] b);
    logic [LENGTH_WIDTH:0] s;
    s = {1'b0, a} + {{(LENGTH_WIDTH + 1 - 8){1'b0}}, b};
    return s[LENGTH_WIDTH] ? '1 : s[LENGTH_WIDTH-1:0];
  endfunction

endpackage

// ----- sv/lz4_block_decoder.sv -----
// lz4_block_decoder: byte-at-a-time lz4 block decoder with a 64 KiB history memory
// depends on lzbd_pkg
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------
//  item     | item_valid / item_stall    | operation, data_byte, last_byte
//  result   | result_valid / result_stall| out_valid, out_byte, status
//
// one beat in and one beat out per clock while result_stall is low; every input beat gives one result beat
// a beat is decoded, with its history read, into the decode stage register, then moves to the result register
// match bytes come from the history memory's registered read; a byte written in the
// same cycle as the read of its address is forwarded
// rst is synchronous and clears the control state; the history memory is not cleared
// result_stall backs up through one decode stage into item_stall

module lz4_block_decoder
  import lzbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       operation,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic [2:0] status
);

  // decoder state
  phase_t                  phase, phase_next;
  logic [LENGTH_WIDTH-1:0] lit_rem, lit_rem_next;
  logic [LENGTH_WIDTH-1:0] match_rem, match_rem_next;
  logic [3:0]              low_nib, low_nib_next;
  logic [7:0]              off_lo, off_lo_next;
  logic [15:0]             match_dist, match_dist_next;
  logic [WIN_AW-1:0]       wpos, wpos_next;
  logic [PROD_W-1:0]       prod, prod_next;
  logic                    finished, finished_next;
  logic [2:0]              end_st, end_st_next;

  // decode results for the current beat
  logic              emit;
  logic              from_mem;
  logic [2:0]        res_status;
  logic [15:0]       new_dist;
  logic [WIN_AW-1:0] rd_addr;

  // pipeline
  logic              item_accept;
  logic              s1_full;
  logic              s1_adv;
  s1_t               s1;
  logic [7:0]        s1_byte;
  logic [7:0]        rd_data;
  logic              fwd_hit;
  logic [7:0]        fwd_data;
  logic              wr_en;

  logic [7:0] win_mem [WINDOW_DEPTH];

  // handshake
  assign s1_adv      = !result_valid || !result_stall;
  assign item_stall  = s1_full && !s1_adv;
  assign item_accept = item_valid && !item_stall;

  assign new_dist = {data_byte, off_lo};
  assign rd_addr  = wpos - match_dist[WIN_AW-1:0];

  // phase register and remaining state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TOKEN;
      lit_rem    <= '0;
      match_rem  <= '0;
      low_nib    <= '0;
      off_lo     <= '0;
      match_dist <= '0;
      wpos       <= '0;
      prod       <= '0;
      finished   <= 1'b0;
      end_st     <= ST_RUN;
    end else if (item_accept) begin
      phase      <= phase_next;
      lit_rem    <= lit_rem_next;
      match_rem  <= match_rem_next;
      low_nib    <= low_nib_next;
      off_lo     <= off_lo_next;
      match_dist <= match_dist_next;
      wpos       <= wpos_next;
      prod       <= prod_next;
      finished   <= finished_next;
      end_st     <= end_st_next;
    end
  end

  // next state and result of one beat
  always_comb begin
    phase_next      = phase;
    lit_rem_next    = lit_rem;
    match_rem_next  = match_rem;
    low_nib_next    = low_nib;
    off_lo_next     = off_lo;
    match_dist_next = match_dist;
    wpos_next       = wpos;
    prod_next       = prod;
    finished_next   = finished;
    end_st_next     = end_st;
    emit            = 1'b0;
    from_mem        = 1'b0;
    res_status      = ST_RUN;

    if (finished) begin
      res_status = end_st;
    end else if (operation == OP_TICK) begin
      // copy one match byte
      if ((phase == PH_MATCH || phase == PH_MATCHFIN) && match_rem != '0) begin
        emit           = 1'b1;
        from_mem       = 1'b1;
        match_rem_next = match_rem - LENGTH_WIDTH'(1);
        if (match_rem == LENGTH_WIDTH'(1)) begin
          if (phase == PH_MATCHFIN) begin
            finished_next = 1'b1;
            end_st_next   = ST_INPUT_END;
            res_status    = ST_INPUT_END;
          end else begin
            phase_next = PH_TOKEN;
          end
        end
      end
    end else begin
      unique case (phase)
        PH_TOKEN: begin
          low_nib_next = data_byte[3:0];
          lit_rem_next = LENGTH_WIDTH'(data_byte[7:4]);
          if (last_byte) begin
            finished_next = 1'b1;
            end_st_next   = (data_byte[7:4] == 4'd0) ? ST_INPUT_END : ST_TRUNC;
            res_status    = end_st_next;
          end else if (data_byte[7:4] == EXT_NIBBLE) begin
            phase_next = PH_LITEXT;
          end else begin
            phase_next = (data_byte[7:4] != 4'd0) ? PH_LIT : PH_OFF0;
          end
        end
        PH_LITEXT: begin
          lit_rem_next = sat_add(lit_rem, data_byte);
          if (last_byte) begin
            finished_next = 1'b1;
            end_st_next   = ST_TRUNC;
            res_status    = ST_TRUNC;
          end else if (data_byte != EXT_BYTE) begin
            phase_next = PH_LIT;
          end
        end
        PH_LIT: begin
          emit = 1'b1;
          if (lit_rem != '0) begin
            lit_rem_next = lit_rem - LENGTH_WIDTH'(1);
          end
          if (lit_rem_next == '0) begin
            if (last_byte) begin
              finished_next = 1'b1;
              end_st_next   = ST_INPUT_END;
              res_status    = ST_INPUT_END;
            end else begin
              phase_next = PH_OFF0;
            end
          end else if (last_byte) begin
            finished_next = 1'b1;
            end_st_next   = ST_TRUNC;
            res_status    = ST_TRUNC;
          end
        end
        PH_OFF0: begin
          if (last_byte) begin
            finished_next = 1'b1;
            end_st_next   = ST_INPUT_END;
            res_status    = ST_INPUT_END;
          end else begin
            off_lo_next = data_byte;
            phase_next  = PH_OFF1;
          end
        end
        PH_OFF1: begin
          match_dist_next = new_dist;
          if (new_dist == 16'd0) begin
            finished_next = 1'b1;
            end_st_next   = ST_ZERO_END;
            res_status    = ST_ZERO_END;
          end else if ({1'b0, new_dist} > 17'(prod)) begin
            finished_next = 1'b1;
            end_st_next   = ST_BAD_DIST;
            res_status    = ST_BAD_DIST;
          end else begin
            match_rem_next = LENGTH_WIDTH'(low_nib) + LENGTH_WIDTH'(MIN_MATCH);
            if (low_nib == EXT_NIBBLE) begin
              if (last_byte) begin
                finished_next = 1'b1;
                end_st_next   = ST_TRUNC;
                res_status    = ST_TRUNC;
              end else begin
                phase_next = PH_MATCHEXT;
              end
            end else begin
              phase_next = last_byte ? PH_MATCHFIN : PH_MATCH;
            end
          end
        end
        PH_MATCHEXT: begin
          match_rem_next = sat_add(match_rem, data_byte);
          if (data_byte == EXT_BYTE) begin
            if (last_byte) begin
              finished_next = 1'b1;
              end_st_next   = ST_TRUNC;
              res_status    = ST_TRUNC;
            end
          end else begin
            phase_next = last_byte ? PH_MATCHFIN : PH_MATCH;
          end
        end
        PH_MATCH, PH_MATCHFIN: begin
          res_status = ST_REFUSED;
        end
      endcase
    end

    // advance the window pointer on every emitted byte
    if (emit) begin
      wpos_next = wpos + WIN_AW'(1);
      if (prod < PROD_W'(WINDOW_DEPTH)) begin
        prod_next = prod + PROD_W'(1);
      end
    end
  end

  // decode stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_full <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      if (item_accept) begin
        s1_full <= 1'b1;
        fwd_hit <= from_mem && wr_en && (s1.waddr == rd_addr);
      end else if (s1_adv) begin
        s1_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      s1.mem_src <= from_mem;
      s1.emit    <= emit;
      s1.lit     <= (emit && !from_mem) ? data_byte : 8'd0;
      s1.status  <= res_status;
      s1.waddr   <= wpos;
      fwd_data   <= s1_byte;
    end
  end

  // byte of the decode stage, with forwarding of a same-cycle write
  assign s1_byte = s1.mem_src ? (fwd_hit ? fwd_data : rd_data) : s1.lit;
  assign wr_en   = s1_full && s1_adv && s1.emit;

  // history memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      win_mem[s1.waddr] <= s1_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept && from_mem) begin
      rd_data <= win_mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= s1_full;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_full) begin
      out_valid <= s1.emit;
      out_byte  <= s1_byte;
      status    <= s1.status;
    end
  end

  // checks
  assert property (@(posedge clk) disable iff (rst)
    item_accept && finished |=> s1_full && !s1.emit && s1.status != ST_RUN)
    else $error("finished decoder produced a byte or a running status");

  assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> s1.mem_src)
    else $error("forward hit on a beat that does not read the history");

  assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_full && result_valid)
    else $error("input stalled while the decode stage can drain");

  assert property (@(posedge clk) disable iff (rst)
    prod <= PROD_W'(WINDOW_DEPTH))
    else $error("produced count passed the window depth");

  assert property (@(posedge clk) disable iff (rst)
    s1_full && !s1_adv && s1.mem_src |=> $stable(rd_data) && $stable(fwd_hit))
    else $error("history read data changed under a stalled decode stage");

endmodule
